/* design/mcfsm_pkg.sv */
package mcfsm_pkg;

  localparam int NUM_CAMERAS  = 4;
  localparam int NUM_CHANNELS = 2;
  localparam int NUM_BUFFERS  = 16;   // ring length, power of two
  localparam int MAX_RESULTS  = 4;

  localparam int RINGS     = NUM_CAMERAS * NUM_CHANNELS;
  localparam int CAM_W     = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  localparam int RING_W    = $clog2(RINGS);
  localparam int BUF_W     = $clog2(NUM_BUFFERS);
  localparam int ADDR_W    = RING_W + BUF_W;
  localparam int STAMP_W   = 63;
  localparam int THR_W     = 4;
  localparam int DELAY_MAX = NUM_BUFFERS - 7;
  localparam int DLY_W     = $clog2(DELAY_MAX + 1);
  localparam int RD_COUNT  = (NUM_CAMERAS < MAX_RESULTS) ? NUM_CAMERAS : MAX_RESULTS;
  localparam int KIND_W    = 3;
  localparam int IN_W      = 80;
  localparam int OUT_W     = 80;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FINISH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADJUST = 3'd4;

  // datapath actions of a control word
  localparam logic [2:0] ACT_FETCH   = 3'd0;
  localparam logic [2:0] ACT_BEGIN   = 3'd1;
  localparam logic [2:0] ACT_FINISH  = 3'd2;
  localparam logic [2:0] ACT_READOUT = 3'd3;
  localparam logic [2:0] ACT_QREAD   = 3'd4;
  localparam logic [2:0] ACT_QEMIT   = 3'd5;
  localparam logic [2:0] ACT_ADJUST  = 3'd6;

  // branch kinds
  localparam logic BR_GO   = 1'b0;   // always to target
  localparam logic BR_LOOP = 1'b1;   // to target until last camera, then idle

  // program addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_BEGIN  = 3'd1;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd2;
  localparam logic [PC_W-1:0] PC_READ   = 3'd3;
  localparam logic [PC_W-1:0] PC_QRY0   = 3'd4;
  localparam logic [PC_W-1:0] PC_QRY1   = 3'd5;
  localparam logic [PC_W-1:0] PC_ADJUST = 3'd6;

  typedef struct packed {
    logic [2:0]      act;
    logic            emit;
    logic            br;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic signed [5:0]  delay_step;
    logic [STAMP_W-1:0] stamp_in;
    logic [3:0]         query_slot;
    logic               channel;
    logic [1:0]         camera;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic               first_ready;
    logic               buffering_ready;
    logic [3:0]         delay_now;
    logic               found;
    logic [STAMP_W-1:0] stamp_out;
    logic [1:0]         camera_out;
    logic [3:0]         slot;
  } out_word_t;

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w.act    = ACT_FETCH;
    w.emit   = 1'b0;
    w.br     = BR_GO;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.act = ACT_FETCH;
      end
      PC_BEGIN: begin
        w.act  = ACT_BEGIN;
        w.emit = 1'b1;
      end
      PC_FINISH: begin
        w.act  = ACT_FINISH;
        w.emit = 1'b1;
      end
      PC_READ: begin
        w.act    = ACT_READOUT;
        w.emit   = 1'b1;
        w.br     = BR_LOOP;
        w.target = PC_READ;
      end
      PC_QRY0: begin
        w.act    = ACT_QREAD;
        w.target = PC_QRY1;
      end
      PC_QRY1: begin
        w.act  = ACT_QEMIT;
        w.emit = 1'b1;
      end
      PC_ADJUST: begin
        w.act  = ACT_ADJUST;
        w.emit = 1'b1;
      end
      default: begin
        w.act = ACT_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry(input logic [KIND_W-1:0] kind);
    logic [PC_W-1:0] pc;
    case (kind)
      KIND_BEGIN:  pc = PC_BEGIN;
      KIND_FINISH: pc = PC_FINISH;
      KIND_READ:   pc = PC_READ;
      KIND_QUERY:  pc = PC_QRY0;
      KIND_ADJUST: pc = PC_ADJUST;
      default:     pc = PC_IDLE;
    endcase
    return pc;
  endfunction

endpackage

/* design/multi_camera_frame_slot_manager.sv */
// Frame slot manager for several cameras, two channels each.
// Input channel (s_axis_*): one command word per handshake; tuser carries the
// command kind (begin capture, finish capture, read out, timestamp query,
// delay adjust), tdata the operands. Kinds 5..7 are taken and dropped.
// Output channel (m_axis_*): result words; tlast marks the final word of a
// command. Read out yields one word per camera (up to four), the rest one.
// Config: cfg_we_i writes cfg_wdata_i into the buffering threshold (reset 3).
// Control is a microcoded sequencer: a fetch step takes the command and jumps
// into a small ROM program; each further step drives the datapath. Begin,
// finish and adjust take the fetch step and one more; a timestamp query
// takes the fetch step, a stamp RAM read and a step that emits the registered
// read data; read out takes the fetch step and one step per camera. The first
// result word appears on m_axis_tvalid_o the cycle after its step.
// A single output register holds the result; an emitting step waits while
// that register is full and not drained, so a stalled receiver freezes the
// sequencer in place and no word is lost. s_axis_tready_o is high only in
// the fetch step.
// Reset clears write positions, captured flags (flip-flops), peak, flags and
// delay at once; the stamp RAM is not cleared, as only captured slots are read.
module multi_camera_frame_slot_manager (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: camera[1:0], channel[2], query_slot[6:3], stamp_in[69:7],
  //        delay_step[75:70], zero pad
  input  logic [mcfsm_pkg::IN_W-1:0]    s_axis_tdata_i,
  // tuser: kind[2:0]
  input  logic [mcfsm_pkg::KIND_W-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: slot[3:0], camera_out[5:4], stamp_out[68:6], found[69],
  //        delay_now[73:70], buffering_ready[74], first_ready[75], zero pad
  output logic [mcfsm_pkg::OUT_W-1:0]   m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_we_i,
  input  logic [mcfsm_pkg::THR_W-1:0]   cfg_wdata_i
);
  import mcfsm_pkg::*;

  // sequencer
  logic [PC_W-1:0]  pc_q;
  logic [CAM_W-1:0] cam_cnt_q;
  ctrl_word_t       cw;
  logic             out_free, go, cam_last;

  // state
  logic [THR_W-1:0]       thr_q;
  logic [BUF_W-1:0]       wpos_q [RINGS];
  logic [NUM_BUFFERS-1:0] captured_q [RINGS];
  logic [STAMP_W-1:0]     stamp_mem [RINGS*NUM_BUFFERS];
  logic [BUF_W-1:0]       peak_q, peak_d;
  logic                   buf_q, buf_d;
  logic                   first_q, first_d;
  logic [DLY_W-1:0]       delay_q, delay_d;

  // command and query registers
  in_word_t               in_q;
  logic                   hit_q;
  logic [STAMP_W-1:0]     rdata_q;
  logic                   hit_c;
  logic [CAM_W-1:0]       hit_cam;
  logic [ADDR_W-1:0]      q_addr;

  // output register
  logic      out_valid_q;
  out_word_t out_q, res;
  logic      res_last, out_last_q;

  // datapath
  logic [CAM_W-1:0]  cur_cam;
  logic [RING_W-1:0] ring_in, ring_rd;
  logic [BUF_W-1:0]  pos_in, pos_inc, lag, slot_rd;
  logic signed [7:0] dly_sum;

  function automatic logic [RING_W-1:0] ring_of(input logic ch, input logic [CAM_W-1:0] cam);
    return RING_W'(int'(ch) * NUM_CAMERAS + int'(cam));
  endfunction

  assign cw       = ucode(pc_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign go       = (cw.act == ACT_FETCH) ? s_axis_tvalid_i : (!cw.emit || out_free);
  assign cam_last = (cam_cnt_q == CAM_W'(RD_COUNT - 1));

  assign s_axis_tready_o = (pc_q == PC_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;

  // capture / advance addressing
  assign cur_cam = CAM_W'(int'(in_q.camera) % NUM_CAMERAS);
  assign ring_in = ring_of(in_q.channel, cur_cam);
  assign pos_in  = wpos_q[ring_in];
  assign pos_inc = pos_in + BUF_W'(1);   // ring length is a power of two

  // read-out: lag wraps with the ring
  assign lag     = in_q.channel ? BUF_W'(1) : (BUF_W'(thr_q) + BUF_W'(delay_q));
  assign ring_rd = ring_of(in_q.channel, cam_cnt_q);
  assign slot_rd = wpos_q[ring_rd] - lag;

  // first camera holding the queried slot captured
  always_comb begin
    hit_c   = 1'b0;
    hit_cam = '0;
    for (int c = NUM_CAMERAS - 1; c >= 0; c--) begin
      if (int'(in_q.query_slot) < NUM_BUFFERS &&
          captured_q[ring_of(in_q.channel, CAM_W'(c))][BUF_W'(in_q.query_slot)]) begin
        hit_c   = 1'b1;
        hit_cam = CAM_W'(c);
      end
    end
  end
  assign q_addr = {ring_of(in_q.channel, hit_cam), BUF_W'(in_q.query_slot)};

  assign dly_sum = $signed({{(8-DLY_W){1'b0}}, delay_q}) -
                   $signed({{2{in_q.delay_step[5]}}, in_q.delay_step});

  always_comb begin
    peak_d   = peak_q;
    buf_d    = buf_q;
    first_d  = first_q;
    delay_d  = delay_q;
    res      = '0;
    res_last = 1'b1;
    case (cw.act)
      ACT_BEGIN: begin
        if (in_q.channel && pos_in != '0) first_d = 1'b1;
        res.slot = 4'(pos_in);
      end
      ACT_FINISH: begin
        if (!buf_q) begin
          peak_d = (peak_q < pos_inc) ? pos_inc : peak_q;
          if (int'(peak_d) > int'(thr_q)) buf_d = 1'b1;
        end
      end
      ACT_READOUT: begin
        res.slot       = 4'(slot_rd);
        res.camera_out = 2'(cam_cnt_q);
        res_last       = cam_last;
      end
      ACT_QEMIT: begin
        res.found     = hit_q;
        res.stamp_out = hit_q ? rdata_q : '0;
      end
      ACT_ADJUST: begin
        if (dly_sum[7]) delay_d = '0;
        else if (int'(dly_sum) > DELAY_MAX) delay_d = DLY_W'(DELAY_MAX);
        else delay_d = DLY_W'(dly_sum);
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
    res.delay_now       = 4'(delay_d);
    res.buffering_ready = buf_d;
    res.first_ready     = first_d;
  end

  // control and flag state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      cam_cnt_q   <= '0;
      thr_q       <= THR_W'(3);
      peak_q      <= '0;
      buf_q       <= 1'b0;
      first_q     <= 1'b0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      for (int r = 0; r < RINGS; r++) begin
        wpos_q[r]     <= '0;
        captured_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;

      if (go && cw.emit) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;

      if (go) begin
        peak_q  <= peak_d;
        buf_q   <= buf_d;
        first_q <= first_d;
        delay_q <= delay_d;
        case (cw.act)
          ACT_FETCH: begin
            pc_q      <= entry(s_axis_tuser_i);
            cam_cnt_q <= '0;
          end
          ACT_BEGIN: begin
            captured_q[ring_in][pos_in] <= 1'b0;
          end
          ACT_FINISH: begin
            captured_q[ring_in][pos_in] <= 1'b1;
            wpos_q[ring_in]             <= pos_inc;
          end
          ACT_READOUT: begin
            cam_cnt_q <= cam_cnt_q + CAM_W'(1);
          end
          ACT_QREAD: begin
            hit_q <= hit_c;
          end
          default: begin
            hit_q <= hit_q;
          end
        endcase
        if (cw.act != ACT_FETCH) begin
          if (cw.br == BR_LOOP && !cam_last) pc_q <= cw.target;
          else if (cw.br == BR_LOOP) pc_q <= PC_IDLE;
          else pc_q <= cw.target;
        end
      end
    end
  end

  // payload registers and stamp RAM
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_q <= s_axis_tdata_i;
    if (go && cw.act == ACT_FINISH) stamp_mem[{ring_in, pos_in}] <= in_q.stamp_in;
    if (go && cw.act == ACT_QREAD) rdata_q <= stamp_mem[q_addr];
    if (go && cw.emit) begin
      out_q      <= res;
      out_last_q <= res_last;
    end
  end

endmodule

/* design/mcfsm_checker.sv */
module mcfsm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [mcfsm_pkg::OUT_W-1:0]   m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);
  import mcfsm_pkg::*;

  out_word_t ow;
  assign ow = m_axis_tdata_o;

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result word changed while stalled");

  // a stamp is only returned together with found
  a_stamp_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !ow.found |-> ow.stamp_out == '0)
    else $error("stamp without found");

  // delay stays clamped
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> int'(ow.delay_now) <= DELAY_MAX)
    else $error("delay out of range");

  // only read-out gives non-final words, and never for its last camera
  a_readout_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      int'(ow.camera_out) != RD_COUNT - 1 && !ow.found && ow.stamp_out == '0)
    else $error("bad non-final result word");

endmodule

bind multi_camera_frame_slot_manager mcfsm_checker u_mcfsm_checker (.*);
